@@ rtl/hcc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared constants and types for the hashed coordinate cache: field widths,
// mixer constants, table entry layout and the hash unit request/response.
// ----------------------------------------------------------------------------
package hcc_pkg;

  // Table geometry; CAPACITY must be a power of two
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);

  // Field widths
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned XZ_W     = 28;
  localparam int unsigned Y_W      = 8;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned HALF_W   = KEY_W / 2;

  // 64-bit finalizer constants
  localparam logic [KEY_W-1:0] MIX_MUL1  = 64'hFF51_AFD7_ED55_8CCD;
  localparam logic [KEY_W-1:0] MIX_MUL2  = 64'hC4CE_B9FE_1A85_EC53;
  localparam int unsigned      MIX_SHIFT = 33;

  // Item kinds
  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    key_t    key;
    sample_t value;
  } entry_t;

  localparam int unsigned ENTRY_W     = $bits(entry_t);
  localparam entry_t      ENTRY_CLEAR = '{key: '1, value: '0};

  typedef struct packed {
    logic start;
    key_t key;
  } hash_req_t;

  typedef struct packed {
    logic done;
    idx_t slot;
  } hash_rsp_t;

endpackage
`default_nettype wire

@@ rtl/hcc_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hcc_if
// Valid/ready channels of the hashed coordinate cache: the request channel
// carries one coordinate access or clear, the response channel one sample.
// ----------------------------------------------------------------------------
interface hcc_req_if import hcc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [XZ_W-1:0]   coord_x;
  logic signed [Y_W-1:0]    coord_y;
  logic signed [XZ_W-1:0]   coord_z;
  logic [SAMPLE_W-1:0]      fresh_sample;

  modport source (output valid, kind, coord_x, coord_y, coord_z, fresh_sample,
                  input ready);
  modport sink   (input valid, kind, coord_x, coord_y, coord_z, fresh_sample,
                  output ready);
endinterface

interface hcc_rsp_if import hcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_out;
  logic                was_hit;

  modport source (output valid, sample_out, was_hit, input ready);
  modport sink   (input valid, sample_out, was_hit, output ready);
endinterface
`default_nettype wire

@@ rtl/hcc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hcc_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read word.
// ----------------------------------------------------------------------------
module hcc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 80,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/hcc_hash.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hcc_hash
// Iterative 64-bit finalizer. Each 64x64 (low half) multiply is built from
// three 32x32 partial products on one shared multiplier; the slot index is
// the low bits of the mixed key.
// ----------------------------------------------------------------------------
module hcc_hash import hcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hash_req_t req_i,
  output hash_rsp_t rsp_o
);

  typedef enum logic [4:0] {
    HS_IDLE = 5'b00001,
    HS_LL   = 5'b00010,
    HS_HL   = 5'b00100,
    HS_LH   = 5'b01000,
    HS_FOLD = 5'b10000
  } hash_step_e;

  hash_step_e        step_q, step_d;
  logic              round_q, round_d;
  logic              done_q, done_d;
  key_t              x_q;
  logic [KEY_W-1:0]  prod_q;
  logic [KEY_W-1:0]  acc_q;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [KEY_W-1:0]  prod_d;
  key_t              mul_c;
  key_t              mul_full;

  function automatic key_t xor_shift(input key_t k);
    return k ^ (k >> MIX_SHIFT);
  endfunction

  assign mul_c = round_q ? MIX_MUL2 : MIX_MUL1;

  // Pick the partial product for this step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      HS_LL: begin
        mul_a = x_q[HALF_W-1:0];
        mul_b = mul_c[HALF_W-1:0];
      end
      HS_HL: begin
        mul_a = x_q[KEY_W-1:HALF_W];
        mul_b = mul_c[HALF_W-1:0];
      end
      HS_LH: begin
        mul_a = x_q[HALF_W-1:0];
        mul_b = mul_c[KEY_W-1:HALF_W];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Full 64-bit product of the two 32-bit operands
  assign prod_d   = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
  assign mul_full = {acc_q[KEY_W-1:HALF_W] + prod_q[HALF_W-1:0], acc_q[HALF_W-1:0]};

  always_comb begin
    step_d  = step_q;
    round_d = round_q;
    done_d  = 1'b0;
    case (step_q)
      HS_IDLE: begin
        if (req_i.start) begin
          step_d  = HS_LL;
          round_d = 1'b0;
        end
      end
      HS_LL:   step_d = HS_HL;
      HS_HL:   step_d = HS_LH;
      HS_LH:   step_d = HS_FOLD;
      HS_FOLD: begin
        if (round_q) begin
          step_d = HS_IDLE;
          done_d = 1'b1;
        end else begin
          step_d  = HS_LL;
          round_d = 1'b1;
        end
      end
      default: step_d = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= HS_IDLE;
      round_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      step_q  <= step_d;
      round_q <= round_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (step_q)
      HS_IDLE: begin
        if (req_i.start) begin
          x_q <= xor_shift(req_i.key);
        end
      end
      HS_LL: prod_q <= prod_d;
      HS_HL: begin
        prod_q <= prod_d;
        acc_q  <= prod_q;
      end
      HS_LH: begin
        prod_q                <= prod_d;
        acc_q[KEY_W-1:HALF_W] <= acc_q[KEY_W-1:HALF_W] + prod_q[HALF_W-1:0];
      end
      HS_FOLD: x_q <= xor_shift(mul_full);
      default: x_q <= x_q;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.slot = x_q[IDX_W-1:0];

endmodule
`default_nettype wire

@@ rtl/hashed_coordinate_cache.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_coordinate_cache
// Direct-mapped sample cache keyed by packed 3-D coordinates.
// ----------------------------------------------------------------------------
// A coordinate access runs the iterative key mixer (two 64-bit multiplies on
// one 32x32 multiplier), then the table read, then compare and write-back,
// and then returns to idle with the request channel ready. The compare step
// stretches for as long as the output register still holds an untaken word.
// A clear sweeps the table one entry per cycle and then returns a zero word;
// after reset the same sweep runs with the request channel held not ready.
// A finished word waits in the output register while the next request is
// taken. The coordinate (-1,-1,-1) packs to the all-ones key and therefore
// hits with zero on an entry that was cleared.
// ----------------------------------------------------------------------------
module hashed_coordinate_cache import hcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  hcc_req_if.sink   sample_req_i,
  hcc_rsp_if.source sample_rsp_o
);

  typedef enum logic [4:0] {
    ST_SWEEP   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_HASH    = 5'b00100,
    ST_CMP     = 5'b01000,
    ST_CLR_RSP = 5'b10000
  } ctl_state_e;

  ctl_state_e state_q, state_d;
  idx_t       sweep_idx_q, sweep_idx_d;
  logic       clr_rsp_q, clr_rsp_d;
  logic       out_valid_q, out_valid_d;
  sample_t    out_sample_q, out_sample_d;
  logic       out_hit_q, out_hit_d;
  key_t       key_q;
  sample_t    fresh_q;
  idx_t       slot_q;

  logic       req_fire;
  logic       out_free;
  logic       out_load;
  logic       hit;
  key_t       req_key;

  hash_req_t  hash_req;
  hash_rsp_t  hash_rsp;

  logic       ram_we;
  idx_t       ram_waddr;
  entry_t     ram_wdata;
  logic       ram_re;
  entry_t     ram_rdata;

  assign req_key = {sample_req_i.coord_y[Y_W-1:0],
                    sample_req_i.coord_z[XZ_W-1:0],
                    sample_req_i.coord_x[XZ_W-1:0]};

  assign sample_req_i.ready = (state_q == ST_IDLE);
  assign req_fire           = sample_req_i.valid & sample_req_i.ready;
  assign out_free           = !out_valid_q || sample_rsp_o.ready;

  assign hash_req.start = req_fire && (sample_req_i.kind == KIND_ACCESS);
  assign hash_req.key   = req_key;

  hcc_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hash_req),
    .rsp_o  (hash_rsp)
  );

  hcc_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (hash_rsp.slot),
    .rdata_o (ram_rdata)
  );

  assign hit = (ram_rdata.key == key_q);

  always_comb begin
    state_d      = state_q;
    sweep_idx_d  = sweep_idx_q;
    clr_rsp_d    = clr_rsp_q;
    out_load     = 1'b0;
    out_sample_d = out_sample_q;
    out_hit_d    = out_hit_q;
    ram_we       = 1'b0;
    ram_waddr    = sweep_idx_q;
    ram_wdata    = ENTRY_CLEAR;
    ram_re       = 1'b0;
    case (state_q)
      ST_SWEEP: begin
        ram_we      = 1'b1;
        sweep_idx_d = sweep_idx_q + 1'b1;
        if (sweep_idx_q == '1) begin
          state_d = clr_rsp_q ? ST_CLR_RSP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          if (sample_req_i.kind == KIND_CLEAR) begin
            state_d     = ST_SWEEP;
            sweep_idx_d = '0;
            clr_rsp_d   = 1'b1;
          end else begin
            state_d = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        // Read the slot as soon as the mixer finishes
        if (hash_rsp.done) begin
          ram_re  = 1'b1;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        // Hold the read word until the output register frees up
        if (out_free) begin
          out_load     = 1'b1;
          out_sample_d = hit ? ram_rdata.value : fresh_q;
          out_hit_d    = hit;
          state_d      = ST_IDLE;
          if (!hit) begin
            ram_we    = 1'b1;
            ram_waddr = slot_q;
            ram_wdata = '{key: key_q, value: fresh_q};
          end
        end
      end
      ST_CLR_RSP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_sample_d = '0;
          out_hit_d    = 1'b0;
          clr_rsp_d    = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !sample_rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_idx_q <= '0;
      clr_rsp_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_idx_q <= sweep_idx_d;
      clr_rsp_q   <= clr_rsp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sample_q <= out_sample_d;
    out_hit_q    <= out_hit_d;
    if (req_fire) begin
      key_q   <= req_key;
      fresh_q <= sample_req_i.fresh_sample;
    end
    if (state_q == ST_HASH && hash_rsp.done) begin
      slot_q <= hash_rsp.slot;
    end
  end

  assign sample_rsp_o.valid      = out_valid_q;
  assign sample_rsp_o.sample_out = out_sample_q;
  assign sample_rsp_o.was_hit    = out_hit_q;

endmodule
`default_nettype wire

@@ rtl/hcc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hcc_checker
// Port-level checks for the hashed coordinate cache: request pacing, output
// word hold, and matching of response words to accepted requests.
// ----------------------------------------------------------------------------
module hcc_checker import hcc_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                req_valid_i,
  input wire logic                req_ready_i,
  input wire logic                rsp_valid_i,
  input wire logic                rsp_ready_i,
  input wire logic [SAMPLE_W-1:0] rsp_sample_i,
  input wire logic                rsp_hit_i
);

  logic       req_fire;
  logic       rsp_fire;
  logic [1:0] pend_q, pend_d;

  assign req_fire = req_valid_i & req_ready_i;
  assign rsp_fire = rsp_valid_i & rsp_ready_i;
  assign pend_d   = pend_q + {1'b0, req_fire} - {1'b0, rsp_fire};

  // Count requests whose word has not been taken yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_ready_i)
    else $error("request channel ready right after an accepted word");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_sample_i) && $stable(rsp_hit_i))
    else $error("stalled response word changed");

  a_no_orphan_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 2'd0)
    else $error("response word without an accepted request");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two requests outstanding");

endmodule

bind hashed_coordinate_cache hcc_checker u_hcc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (sample_req_i.valid),
  .req_ready_i  (sample_req_i.ready),
  .rsp_valid_i  (sample_rsp_o.valid),
  .rsp_ready_i  (sample_rsp_o.ready),
  .rsp_sample_i (sample_rsp_o.sample_out),
  .rsp_hit_i    (sample_rsp_o.was_hit)
);
`default_nettype wire

@@ tb/tb_hashed_coordinate_cache.sv @@
// ----------------------------------------------------------------------------
// tb_hashed_coordinate_cache
// Self-checking bench for the hashed coordinate cache. A directed table covers
// reset contents, field extremes, the all-ones coordinate and clears. Random
// accesses then revisit, evict and clear entries under random idle and stall
// bursts. A shadow copy of the table predicts every response word but those of the typed directed rows.
// ----------------------------------------------------------------------------
module tb_hashed_coordinate_cache;
  import hcc_pkg::*;

  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned RANDOM_WORDS = 530;
  localparam int unsigned QUIET_WORDS  = 60;
  localparam int unsigned POOL_DEPTH   = 48;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned LIMIT_CYCLES = 1_200_000;

  // Field order matches the key layout: y on top, then z, x at the bottom
  typedef struct packed {
    logic [Y_W-1:0]  y;
    logic [XZ_W-1:0] z;
    logic [XZ_W-1:0] x;
  } coord_t;

  typedef struct packed {
    logic    kind;
    coord_t  pos;
    sample_t fresh;
  } access_t;

  typedef struct packed {
    sample_t sample;
    logic    hit;
  } lookup_t;

  typedef struct packed {
    logic    kind;
    coord_t  pos;
    sample_t fresh;
    logic    typed;
    sample_t want_sample;
    logic    want_hit;
  } dir_row_t;

  localparam logic TYPED = 1'b1;
  localparam logic MODEL = 1'b0;
  localparam logic HIT   = 1'b1;
  localparam logic MISS  = 1'b0;

  localparam coord_t ONES   = '1;
  localparam coord_t ORIGIN = '0;
  localparam coord_t CMAX   = '{y: 8'h7F, z: 28'h7FF_FFFF, x: 28'h7FF_FFFF};
  localparam coord_t CMIN   = '{y: 8'h80, z: 28'h800_0000, x: 28'h800_0000};

  localparam int unsigned DIR_ROWS = 25;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{KIND_ACCESS, ONES,   16'hABCD, TYPED, 16'h0000, HIT},
    '{KIND_ACCESS, ORIGIN, 16'hFFFF, TYPED, 16'hFFFF, MISS},
    '{KIND_ACCESS, ORIGIN, 16'h1234, TYPED, 16'hFFFF, HIT},
    '{KIND_ACCESS, CMAX,   16'h0000, TYPED, 16'h0000, MISS},
    '{KIND_ACCESS, CMAX,   16'h5555, TYPED, 16'h0000, HIT},
    '{KIND_ACCESS, CMIN,   16'h8000, TYPED, 16'h8000, MISS},
    '{KIND_ACCESS, CMIN,   16'h0001, TYPED, 16'h8000, HIT},
    '{KIND_ACCESS, '{8'hFF, 28'h000_0000, 28'hFFF_FFFF}, 16'h00FF, TYPED, 16'h00FF, MISS},
    '{KIND_ACCESS, '{8'h7F, 28'hFFF_FFFF, 28'hFFF_FFFF}, 16'h0F0F, TYPED, 16'h0F0F, MISS},
    '{KIND_ACCESS, ONES,   16'h7777, MODEL, 16'h0000, MISS},
    '{KIND_ACCESS, '{8'h55, 28'hAAA_AAAA, 28'h555_5555}, 16'hAAAA, TYPED, 16'hAAAA, MISS},
    '{KIND_ACCESS, '{8'hAA, 28'h555_5555, 28'hAAA_AAAA}, 16'h5555, TYPED, 16'h5555, MISS},
    '{KIND_ACCESS, '{8'h00, 28'h000_0000, 28'h000_0001}, 16'h0101, MODEL, 16'h0000, MISS},
    '{KIND_ACCESS, '{8'h01, 28'h000_0000, 28'h000_0000}, 16'h0202, MODEL, 16'h0000, MISS},
    '{KIND_ACCESS, '{8'h00, 28'h000_0001, 28'h000_0000}, 16'h0404, MODEL, 16'h0000, MISS},
    '{KIND_CLEAR,  ONES,   16'h9999, TYPED, 16'h0000, MISS},
    '{KIND_ACCESS, ORIGIN, 16'h2222, TYPED, 16'h2222, MISS},
    '{KIND_ACCESS, ONES,   16'h3333, MODEL, 16'h0000, MISS},
    '{KIND_ACCESS, ORIGIN, 16'h4444, MODEL, 16'h0000, MISS},
    '{KIND_CLEAR,  ORIGIN, 16'h0000, TYPED, 16'h0000, MISS},
    '{KIND_ACCESS, ONES,   16'hFFFF, TYPED, 16'h0000, HIT},
    '{KIND_ACCESS, ONES,   16'h0000, TYPED, 16'h0000, HIT},
    '{KIND_ACCESS, CMAX,   16'h6666, TYPED, 16'h6666, MISS},
    '{KIND_CLEAR,  CMAX,   16'hFFFF, TYPED, 16'h0000, MISS},
    '{KIND_ACCESS, CMAX,   16'h1357, TYPED, 16'h1357, MISS}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  hcc_req_if req_if ();
  hcc_rsp_if rsp_if ();

  hashed_coordinate_cache u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_req_i (req_if),
    .sample_rsp_o (rsp_if)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  key_t        shadow_keys [CAPACITY];
  sample_t     shadow_vals [CAPACITY];
  lookup_t     expected_words [$];
  coord_t      known_coords [$];
  int unsigned mismatches = 0;
  int unsigned idle_odds  = 0;

  function automatic key_t mix_key(key_t k);
    k = k ^ (k >> MIX_SHIFT);
    k = k * MIX_MUL1;
    k = k ^ (k >> MIX_SHIFT);
    k = k * MIX_MUL2;
    k = k ^ (k >> MIX_SHIFT);
    return k;
  endfunction

  function automatic idx_t slot_of(coord_t c);
    return idx_t'(mix_key(key_t'(c)));
  endfunction

  function automatic void wipe_shadow();
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_keys[i] = '1;
      shadow_vals[i] = '0;
    end
  endfunction

  // Look up one access in the shadow table and apply its write-back
  function automatic lookup_t cache_lookup(access_t a);
    key_t    key;
    idx_t    slot;
    lookup_t r;
    if (a.kind == KIND_CLEAR) begin
      wipe_shadow();
      return '0;
    end
    key  = key_t'(a.pos);
    slot = slot_of(a.pos);
    if (shadow_keys[slot] == key) begin
      r = '{sample: shadow_vals[slot], hit: 1'b1};
    end else begin
      shadow_keys[slot] = key;
      shadow_vals[slot] = a.fresh;
      r = '{sample: a.fresh, hit: 1'b0};
    end
    return r;
  endfunction

  function automatic coord_t random_coord();
    coord_t c;
    c.x = XZ_W'($urandom);
    c.y = Y_W'($urandom);
    c.z = XZ_W'($urandom);
    return c;
  endfunction

  function automatic logic [XZ_W-1:0] extreme_xz();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return {1'b0, {(XZ_W-1){1'b1}}};
      3:       return {1'b1, {(XZ_W-1){1'b0}}};
      default: return XZ_W'($urandom);
    endcase
  endfunction

  function automatic logic [Y_W-1:0] extreme_y();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return {1'b0, {(Y_W-1){1'b1}}};
      3:       return {1'b1, {(Y_W-1){1'b0}}};
      default: return Y_W'($urandom);
    endcase
  endfunction

  // Find a different coordinate that lands on the victim's slot
  function automatic coord_t rival_of(coord_t victim);
    coord_t c;
    idx_t   target;
    target = slot_of(victim);
    for (int t = 0; t < 8 * CAPACITY; t++) begin
      c = random_coord();
      if (c != victim && slot_of(c) == target) return c;
    end
    return random_coord();
  endfunction

  function automatic void remember(coord_t c);
    known_coords.push_back(c);
    if (known_coords.size() > POOL_DEPTH) void'(known_coords.pop_front());
  endfunction

  function automatic access_t random_access();
    access_t     a;
    int unsigned roll;
    a.kind  = KIND_ACCESS;
    a.fresh = sample_t'($urandom);
    a.pos   = random_coord();
    roll    = $urandom_range(0, 199);
    if (roll < 3) begin
      a.kind = KIND_CLEAR;
    end else if (roll < 90 && known_coords.size() != 0) begin
      a.pos = known_coords[$urandom_range(0, known_coords.size() - 1)];
    end else if (roll < 110 && known_coords.size() != 0) begin
      a.pos = rival_of(known_coords[$urandom_range(0, known_coords.size() - 1)]);
      remember(a.pos);
    end else if (roll < 125) begin
      // all-ones coordinate, or a near miss of it
      a.pos = ONES;
      case ($urandom_range(0, 3))
        0:       a.pos.x = XZ_W'($urandom);
        1:       a.pos.y = Y_W'($urandom);
        2:       a.pos.z = XZ_W'($urandom);
        default: ;
      endcase
    end else if (roll < 145) begin
      a.pos = '{y: extreme_y(), z: extreme_xz(), x: extreme_xz()};
      remember(a.pos);
    end else begin
      remember(a.pos);
    end
    return a;
  endfunction

  // Present one word from a falling edge and return on a falling edge once it is taken
  task automatic send_word(access_t a, logic typed, lookup_t want);
    lookup_t guess;
    if (idle_odds != 0 && $urandom_range(0, 7) < idle_odds) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.kind         <= a.kind;
    req_if.coord_x      <= a.pos.x;
    req_if.coord_y      <= a.pos.y;
    req_if.coord_z      <= a.pos.z;
    req_if.fresh_sample <= a.fresh;
    do @(posedge clk_i); while (!req_if.ready);
    guess = cache_lookup(a);
    expected_words.push_back(typed ? want : guess);
    @(negedge clk_i);
  endtask

  initial begin
    access_t  a;
    lookup_t  want;
    dir_row_t row;
    req_if.valid        = 1'b0;
    req_if.kind         = KIND_ACCESS;
    req_if.coord_x      = '0;
    req_if.coord_y      = '0;
    req_if.coord_z      = '0;
    req_if.fresh_sample = '0;
    wipe_shadow();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_odds = 1;
    for (int i = 0; i < DIR_ROWS; i++) begin
      row  = DIR_TABLE[i];
      a    = '{kind: row.kind, pos: row.pos, fresh: row.fresh};
      want = '{sample: row.want_sample, hit: row.want_hit};
      send_word(a, row.typed, want);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) idle_odds = $urandom_range(0, 3);
      if (n >= RANDOM_WORDS - QUIET_WORDS) idle_odds = 0;
      send_word(random_access(), MODEL, '0);
    end
    req_if.valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_hashed_coordinate_cache: done, clean");
    end else begin
      $display("tb_hashed_coordinate_cache: done, errors");
    end
    $finish;
  end

  // Response side: stall in bursts while idling is on
  initial begin
    int unsigned hold;
    hold         = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        rsp_if.ready <= 1'b0;
      end else if (hold != 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, 15) < idle_odds) begin
        hold = $urandom_range(0, 15);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: sample_out %h was_hit %b",
               rsp_if.sample_out, rsp_if.was_hit);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (rsp_if.sample_out !== want.sample) begin
          $error("sample_out: expected %h, got %h", want.sample, rsp_if.sample_out);
          mismatches++;
        end
        if (rsp_if.was_hit !== want.hit) begin
          $error("was_hit: expected %b, got %b", want.hit, rsp_if.was_hit);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("tb_hashed_coordinate_cache: done, errors");
    $finish;
  end

endmodule

@@ hashed_coordinate_cache.f @@
rtl/hcc_pkg.sv
rtl/hcc_if.sv
rtl/hcc_ram.sv
rtl/hcc_hash.sv
rtl/hashed_coordinate_cache.sv
rtl/hcc_checker.sv
tb/tb_hashed_coordinate_cache.sv
